// File: hw/rtl/assert_macros.svh
// Assertion macros shared by the RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_IMPLIES(lbl, clk, rst_n, a, c) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
    else $error("assertion failed");
`define ASSERT_NEXT(lbl, clk, rst_n, a, c) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
    else $error("assertion failed");
`else
`define ASSERT_IMPLIES(lbl, clk, rst_n, a, c)
`define ASSERT_NEXT(lbl, clk, rst_n, a, c)
`endif
`endif

// File: hw/rtl/aarm_pkg.sv
// Package with types, constants and tables for the axis-angle converter.
package aarm_pkg;
  localparam int CordicStages = 14;
  localparam int AngW = 34;
  localparam int CordW = 32;
  localparam int FifoDepth = 4;
  localparam int FifoAw = 2;
  localparam logic signed [AngW-1:0] AngPi = 34'sd3373259426;
  localparam logic signed [AngW-1:0] AngHalfPi = 34'sd1686629713;
  localparam logic signed [CordW-1:0] CordicGain = 32'sd652032874;

  typedef struct packed {
    logic signed [AngW-1:0] z;
    logic                   flip;
    logic signed [15:0]     ax;
    logic signed [15:0]     ay;
    logic signed [15:0]     az;
  } front_item_t;

  typedef struct packed {
    logic signed [15:0] m00;
    logic signed [15:0] m01;
    logic signed [15:0] m02;
    logic signed [15:0] m10;
    logic signed [15:0] m11;
    logic signed [15:0] m12;
    logic signed [15:0] m20;
    logic signed [15:0] m21;
    logic signed [15:0] m22;
  } matrix_t;

  function automatic logic signed [AngW-1:0] atan_of(input int i);
    logic signed [AngW-1:0] r;
    case (i)
      0: r = 34'sd843314856;
      1: r = 34'sd497837829;
      2: r = 34'sd263043836;
      3: r = 34'sd133525158;
      4: r = 34'sd67021686;
      5: r = 34'sd33543515;
      6: r = 34'sd16775850;
      7: r = 34'sd8388437;
      8: r = 34'sd4194282;
      9: r = 34'sd2097149;
      10: r = 34'sd1048575;
      11: r = 34'sd524287;
      12: r = 34'sd262143;
      13: r = 34'sd131071;
      14: r = 34'sd65535;
      15: r = 34'sd32767;
      16: r = 34'sd16383;
      17: r = 34'sd8191;
      18: r = 34'sd4095;
      19: r = 34'sd2047;
      20: r = 34'sd1023;
      21: r = 34'sd511;
      22: r = 34'sd255;
      default: r = 34'sd127;
    endcase
    return r;
  endfunction

  // Round a 2^-48 sum to 2^-14 and clamp to plus or minus one.
  function automatic logic signed [15:0] finish(input logic signed [63:0] v);
    logic signed [63:0] r;
    r = (v + (64'sd1 <<< 33)) >>> 34;
    if (r > 64'sd16384) r = 64'sd16384;
    if (r < -64'sd16384) r = -64'sd16384;
    return r[15:0];
  endfunction
endpackage

// File: hw/rtl/aarm_front.sv
// Front end: accepts items, wraps and folds the angle into a right angle.
module aarm_front (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic signed [15:0]    in_angle,
  input  logic signed [15:0]    in_axis_x,
  input  logic signed [15:0]    in_axis_y,
  input  logic signed [15:0]    in_axis_z,
  output logic                  fr_valid,
  input  logic                  fr_ready,
  output aarm_pkg::front_item_t fr_item
);
  logic                  valid_r, valid_nxt;
  aarm_pkg::front_item_t item_r, item_nxt;
  logic signed [aarm_pkg::AngW-1:0] z;

  assign in_ready = !valid_r || fr_ready;

  always_comb begin
    z = {{(aarm_pkg::AngW-33){in_angle[15]}}, in_angle, 17'd0};
    if (z > aarm_pkg::AngPi) z = z - (aarm_pkg::AngPi <<< 1);
    else if (z < -aarm_pkg::AngPi) z = z + (aarm_pkg::AngPi <<< 1);
    item_nxt = item_r;
    item_nxt.flip = 1'b0;
    if (z > aarm_pkg::AngHalfPi) begin
      z = z - aarm_pkg::AngPi;
      item_nxt.flip = 1'b1;
    end else if (z < -aarm_pkg::AngHalfPi) begin
      z = z + aarm_pkg::AngPi;
      item_nxt.flip = 1'b1;
    end
    item_nxt.z  = z;
    item_nxt.ax = in_axis_x;
    item_nxt.ay = in_axis_y;
    item_nxt.az = in_axis_z;
    valid_nxt = in_valid ? 1'b1 : (fr_ready ? 1'b0 : valid_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) valid_r <= 1'b0;
    else if (in_ready) valid_r <= valid_nxt;
    if (in_valid && in_ready) item_r <= item_nxt;
  end

  assign fr_valid = valid_r;
  assign fr_item  = item_r;
endmodule

// File: hw/rtl/aarm_fifo.sv
// Short queue between the front end and the back end.
`include "assert_macros.svh"
module aarm_fifo (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  wr_valid,
  output logic                  wr_ready,
  input  aarm_pkg::front_item_t wr_item,
  output logic                  rd_valid,
  input  logic                  rd_ready,
  output aarm_pkg::front_item_t rd_item
);
  aarm_pkg::front_item_t mem_r [aarm_pkg::FifoDepth];
  logic [aarm_pkg::FifoAw-1:0] wp_r, rp_r;
  logic [aarm_pkg::FifoAw:0]   cnt_r, cnt_nxt;
  logic wr_en, rd_en;

  assign wr_ready = cnt_r != (aarm_pkg::FifoAw+1)'(aarm_pkg::FifoDepth);
  assign rd_valid = cnt_r != '0;
  assign wr_en = wr_valid && wr_ready;
  assign rd_en = rd_valid && rd_ready;
  assign rd_item = mem_r[rp_r];

  always_comb begin
    cnt_nxt = cnt_r;
    if (wr_en && !rd_en) cnt_nxt = cnt_r + 1'b1;
    else if (rd_en && !wr_en) cnt_nxt = cnt_r - 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= '0;
      rp_r <= '0;
      cnt_r <= '0;
    end else begin
      if (wr_en) wp_r <= wp_r + 1'b1;
      if (rd_en) rp_r <= rp_r + 1'b1;
      cnt_r <= cnt_nxt;
    end
    if (wr_en) mem_r[wp_r] <= wr_item;
  end

  `ASSERT_IMPLIES(a_cnt_range, clk, rst_n, 1'b1, cnt_r <= (aarm_pkg::FifoAw+1)'(aarm_pkg::FifoDepth))
  `ASSERT_IMPLIES(a_ptr_gap, clk, rst_n, 1'b1, (wp_r - rp_r) == cnt_r[aarm_pkg::FifoAw-1:0])
  `ASSERT_NEXT(a_cnt_up, clk, rst_n, wr_en && !rd_en, cnt_r == $past(cnt_r) + 1'b1)
endmodule

// File: hw/rtl/aarm_back.sv
// Back end: pipelined CORDIC, products and Rodrigues sums with output stage.
`include "assert_macros.svh"
module aarm_back (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  bk_valid,
  output logic                  bk_ready,
  input  aarm_pkg::front_item_t bk_item,
  output logic                  out_valid,
  input  logic                  out_ready,
  output aarm_pkg::matrix_t     out_mat
);
  localparam int N = aarm_pkg::CordicStages;
  localparam int L = N + 5;
  typedef logic signed [aarm_pkg::CordW-1:0] cw_t;

  logic adv;
  logic [L-1:0] v_r;
  cw_t x_r [N+1];
  cw_t y_r [N+1];
  logic signed [aarm_pkg::AngW-1:0] z_r [N+1];
  logic f_r [N+1];
  logic signed [15:0] ax_r [N+1];
  logic signed [15:0] ay_r [N+1];
  logic signed [15:0] az_r [N+1];

  // Stage after CORDIC: s and c at 2^-20; c reaches two for a half turn.
  logic signed [21:0] s_r;
  logic signed [22:0] c_r;
  logic signed [15:0] bx_r, by_r, bz_r;
  // Products stage.
  logic signed [33:0] n11_r, n22_r, n33_r, n12_r, n13_r, n23_r;
  logic signed [37:0] s1_r, s2_r, s3_r;
  logic signed [22:0] c2_r;
  // Final terms stage.
  logic signed [63:0] d0_r, d4_r, d8_r, p12_r, p13_r, p23_r;
  logic signed [63:0] t1_r, t2_r, t3_r;
  aarm_pkg::matrix_t mat_r;

  assign adv = !v_r[L-1] || out_ready;
  assign bk_ready = adv;

  always_ff @(posedge clk) begin
    if (!rst_n) v_r <= '0;
    else if (adv) v_r <= {v_r[L-2:0], bk_valid};
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      x_r[0] <= aarm_pkg::CordicGain;
      y_r[0] <= '0;
      z_r[0] <= bk_item.z;
      f_r[0] <= bk_item.flip;
      ax_r[0] <= bk_item.ax;
      ay_r[0] <= bk_item.ay;
      az_r[0] <= bk_item.az;
      for (int i = 0; i < N; i++) begin
        if (z_r[i] >= 0) begin
          x_r[i+1] <= x_r[i] - (y_r[i] >>> i);
          y_r[i+1] <= y_r[i] + (x_r[i] >>> i);
          z_r[i+1] <= z_r[i] - aarm_pkg::atan_of(i);
        end else begin
          x_r[i+1] <= x_r[i] + (y_r[i] >>> i);
          y_r[i+1] <= y_r[i] - (x_r[i] >>> i);
          z_r[i+1] <= z_r[i] + aarm_pkg::atan_of(i);
        end
        f_r[i+1] <= f_r[i];
        ax_r[i+1] <= ax_r[i];
        ay_r[i+1] <= ay_r[i];
        az_r[i+1] <= az_r[i];
      end
    end
  end

  logic signed [32:0] xs, ys;
  always_comb begin
    xs = f_r[N] ? -33'(x_r[N]) : 33'(x_r[N]);
    ys = f_r[N] ? -33'(y_r[N]) : 33'(y_r[N]);
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s_r <= 22'((ys + 33'sd512) >>> 10);
      c_r <= 23'sd1048576 - 23'((xs + 33'sd512) >>> 10);
      bx_r <= ax_r[N];
      by_r <= ay_r[N];
      bz_r <= az_r[N];
      n11_r <= 34'(bx_r * bx_r);
      n22_r <= 34'(by_r * by_r);
      n33_r <= 34'(bz_r * bz_r);
      n12_r <= 34'(bx_r * by_r);
      n13_r <= 34'(bx_r * bz_r);
      n23_r <= 34'(by_r * bz_r);
      s1_r <= 38'(bx_r * s_r);
      s2_r <= 38'(by_r * s_r);
      s3_r <= 38'(bz_r * s_r);
      c2_r <= c_r;
      d0_r <= 64'(c2_r * (35'(n22_r) + 35'(n33_r)));
      d4_r <= 64'(c2_r * (35'(n11_r) + 35'(n33_r)));
      d8_r <= 64'(c2_r * (35'(n11_r) + 35'(n22_r)));
      p12_r <= 64'(c2_r * n12_r);
      p13_r <= 64'(c2_r * n13_r);
      p23_r <= 64'(c2_r * n23_r);
      t1_r <= 64'(s1_r) <<< 14;
      t2_r <= 64'(s2_r) <<< 14;
      t3_r <= 64'(s3_r) <<< 14;
      mat_r.m00 <= aarm_pkg::finish((64'sd1 <<< 48) - d0_r);
      mat_r.m01 <= aarm_pkg::finish(p12_r - t3_r);
      mat_r.m02 <= aarm_pkg::finish(p13_r + t2_r);
      mat_r.m10 <= aarm_pkg::finish(p12_r + t3_r);
      mat_r.m11 <= aarm_pkg::finish((64'sd1 <<< 48) - d4_r);
      mat_r.m12 <= aarm_pkg::finish(p23_r - t1_r);
      mat_r.m20 <= aarm_pkg::finish(p13_r - t2_r);
      mat_r.m21 <= aarm_pkg::finish(p23_r + t1_r);
      mat_r.m22 <= aarm_pkg::finish((64'sd1 <<< 48) - d8_r);
    end
  end

  assign out_valid = v_r[L-1];
  assign out_mat = mat_r;

  `ASSERT_NEXT(a_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(out_mat))
  `ASSERT_NEXT(a_shift, clk, rst_n, adv && bk_valid, v_r[0])
  `ASSERT_IMPLIES(a_range, clk, rst_n, out_valid, out_mat.m00 <= 16'sd16384 && out_mat.m00 >= -16'sd16384)
endmodule

// File: hw/rtl/axis_angle_to_rotation_matrix_core.sv
// Top level of the axis-angle to rotation matrix converter.
// This block turns a rotation angle (Q3.13 radians) and an axis (three Q1.14
// components) into the nine entries of the Rodrigues rotation matrix in Q1.14,
// saturated to plus or minus one. It accepts one beat per cycle while the
// output side keeps taking beats and delivers one result beat per input
// beat, in order. A beat passes through the front stage, the queue and the
// unrolled CORDIC pipeline in the back end; throughput is one beat per clock
// while the output side keeps taking beats. A front stage wraps and folds the
// angle, a four-entry queue decouples it from the back end, and the back end
// stalls as a whole when the output is held.
module axis_angle_to_rotation_matrix_core (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic signed [15:0] in_angle,
  input  logic signed [15:0] in_axis_x,
  input  logic signed [15:0] in_axis_y,
  input  logic signed [15:0] in_axis_z,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [15:0] out_m00,
  output logic signed [15:0] out_m01,
  output logic signed [15:0] out_m02,
  output logic signed [15:0] out_m10,
  output logic signed [15:0] out_m11,
  output logic signed [15:0] out_m12,
  output logic signed [15:0] out_m20,
  output logic signed [15:0] out_m21,
  output logic signed [15:0] out_m22
);
  logic fr_valid, fr_ready, bk_valid, bk_ready;
  aarm_pkg::front_item_t fr_item, bk_item;
  aarm_pkg::matrix_t mat;

  aarm_front u_front (
    .clk, .rst_n, .in_valid, .in_ready, .in_angle, .in_axis_x, .in_axis_y,
    .in_axis_z, .fr_valid, .fr_ready, .fr_item
  );

  aarm_fifo u_fifo (
    .clk, .rst_n, .wr_valid(fr_valid), .wr_ready(fr_ready), .wr_item(fr_item),
    .rd_valid(bk_valid), .rd_ready(bk_ready), .rd_item(bk_item)
  );

  aarm_back u_back (
    .clk, .rst_n, .bk_valid, .bk_ready, .bk_item, .out_valid, .out_ready,
    .out_mat(mat)
  );

  assign out_m00 = mat.m00;
  assign out_m01 = mat.m01;
  assign out_m02 = mat.m02;
  assign out_m10 = mat.m10;
  assign out_m11 = mat.m11;
  assign out_m12 = mat.m12;
  assign out_m20 = mat.m20;
  assign out_m21 = mat.m21;
  assign out_m22 = mat.m22;
endmodule
